[rtl/vpts_pkg.sv]
// ----------------------------------------------------------------------------
// vpts_pkg
// Shared types, table layout and saturation helper for the vertex projection
// pipeline.
// ----------------------------------------------------------------------------
package vpts_pkg;

  localparam int unsigned TABLE_DEPTH = 25;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned WIDE_W      = 66;

  // Coefficient table layout.
  localparam int unsigned IDX_MODE = 12;
  localparam int unsigned IDX_P1   = 13;
  localparam int unsigned IDX_P2   = 14;
  localparam int unsigned IDX_P3   = 15;
  localparam int unsigned IDX_P4   = 16;
  localparam int unsigned IDX_P5   = 17;
  localparam int unsigned IDX_P6   = 18;
  localparam int unsigned IDX_VL   = 19;
  localparam int unsigned IDX_VT   = 20;
  localparam int unsigned IDX_VW   = 21;
  localparam int unsigned IDX_VH   = 22;
  localparam int unsigned IDX_VN   = 23;
  localparam int unsigned IDX_VF   = 24;

  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_PROJECT = 1'b1
  } req_type_e;

  typedef logic signed [31:0] word_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [TABLE_DEPTH-1:0][31:0] coef_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } sat_t;

  localparam wide_t SAT_MAX = 66'sd2147483647;
  localparam wide_t SAT_MIN = -66'sd2147483648;

  // Clamp a wide value to the 32-bit signed range.
  function automatic sat_t sat32(input wide_t v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.val = 32'sh7fffffff;
      r.ovf = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val = 32'sh80000000;
      r.ovf = 1'b1;
    end else begin
      r.val = v[31:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

[rtl/vpts_eye.sv]
// ----------------------------------------------------------------------------
// vpts_eye
// Model-view transform: nine products in the first stage, row sums with
// saturation in the second.
// ----------------------------------------------------------------------------
module vpts_eye import vpts_pkg::*; #(
  parameter int unsigned F = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  coef_t coef_i,
  input  logic  valid_i,
  output logic  ready_o,
  input  word_t px_i,
  input  word_t py_i,
  input  word_t pz_i,
  output logic  valid_o,
  input  logic  ready_i,
  output word_t eye_o [3],
  output logic  ovf_o,
  output logic  busy_o
);

  localparam int unsigned N = 2;

  logic [N-1:0] v_q;
  logic [N-1:0] en;

  word_t              pt [3];
  logic signed [63:0] prod_q [3][3];
  word_t              bias_q [3];
  wide_t              acc [3];
  sat_t               s [3];
  word_t              eye_d [3];
  logic               ovf_d;
  word_t              eye_q [3];
  logic               ovf_q;

  assign pt[0] = px_i;
  assign pt[1] = py_i;
  assign pt[2] = pz_i;

  always_comb begin
    en[N-1] = !v_q[N-1] || ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int r = 0; r < 3; r++) begin
        bias_q[r] <= $signed(coef_i[4*r+3]);
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(coef_i[4*r+c]) * pt[c];
        end
      end
    end
  end

  always_comb begin
    ovf_d = 1'b0;
    for (int r = 0; r < 3; r++) begin
      acc[r] = wide_t'(bias_q[r]) + wide_t'(prod_q[r][0] >>> F)
             + wide_t'(prod_q[r][1] >>> F) + wide_t'(prod_q[r][2] >>> F);
      s[r]     = sat32(acc[r]);
      eye_d[r] = s[r].val;
      ovf_d    = ovf_d | s[r].ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      eye_q <= eye_d;
      ovf_q <= ovf_d;
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[N-1];
  assign eye_o   = eye_q;
  assign ovf_o   = ovf_q;
  assign busy_o  = |v_q;

endmodule

[rtl/vpts_proj.sv]
// ----------------------------------------------------------------------------
// vpts_proj
// Projection terms and viewport scaling products, four stages: projection
// products, clip coordinates, scale products, scaled and saturated values.
// ----------------------------------------------------------------------------
module vpts_proj import vpts_pkg::*; #(
  parameter int unsigned F = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  coef_t coef_i,
  input  logic  ortho_i,
  input  logic  valid_i,
  output logic  ready_o,
  input  word_t eye_i [3],
  input  logic  ovf_i,
  output logic  valid_o,
  input  logic  ready_i,
  output word_t t_o [3],
  output word_t ez_o,
  output logic  ovf_o,
  output logic  busy_o
);

  localparam int unsigned N = 4;

  logic [N-1:0] v_q;
  logic [N-1:0] en;

  // Stage 0: projection products.
  logic signed [63:0] pa_q, pb_q, pc_q, pd_q, pe_q;
  word_t              ez0_q;
  logic               ovf0_q;

  // Stage 1: clip coordinates.
  wide_t xs, ys, zs;
  sat_t  xsat, ysat, zsat;
  word_t xc_q, yc_q, zc_q, ez1_q;
  logic  ovf1_q;

  // Stage 2: viewport scale products.
  logic signed [32:0] nyc;
  sat_t               dz;
  logic signed [63:0] txp_q, tzp_q;
  logic signed [64:0] typ_q;
  word_t              ez2_q;
  logic               ovf2_q;

  // Stage 3: scaled values.
  sat_t  tx, ty, tz;
  word_t t_q [3];
  word_t ez3_q;
  logic  ovf3_q;

  always_comb begin
    en[N-1] = !v_q[N-1] || ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pa_q   <= eye_i[0] * $signed(coef_i[IDX_P1]);
      pb_q   <= eye_i[2] * $signed(coef_i[IDX_P2]);
      pc_q   <= eye_i[1] * $signed(coef_i[IDX_P3]);
      pd_q   <= eye_i[2] * $signed(coef_i[IDX_P4]);
      pe_q   <= eye_i[2] * $signed(coef_i[IDX_P5]);
      ez0_q  <= eye_i[2];
      ovf0_q <= ovf_i;
    end
  end

  // Orthographic mode adds the constant offsets, perspective mode the z terms.
  always_comb begin
    if (ortho_i) begin
      xs = wide_t'($signed(coef_i[IDX_P2])) + wide_t'(pa_q >>> F);
      ys = wide_t'($signed(coef_i[IDX_P4])) + wide_t'(pc_q >>> F);
    end else begin
      xs = wide_t'(pa_q >>> F) + wide_t'(pb_q >>> F);
      ys = wide_t'(pc_q >>> F) + wide_t'(pd_q >>> F);
    end
    zs   = wide_t'($signed(coef_i[IDX_P6])) + wide_t'(pe_q >>> F);
    xsat = sat32(xs);
    ysat = sat32(ys);
    zsat = sat32(zs);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      xc_q   <= xsat.val;
      yc_q   <= ysat.val;
      zc_q   <= zsat.val;
      ez1_q  <= ez0_q;
      ovf1_q <= ovf0_q | xsat.ovf | ysat.ovf | zsat.ovf;
    end
  end

  // The y axis is flipped, so y is negated exactly in 33 bits.
  always_comb begin
    nyc = -(33'(yc_q));
    dz  = sat32(wide_t'($signed(coef_i[IDX_VF])) - wide_t'($signed(coef_i[IDX_VN])));
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      txp_q  <= xc_q * $signed(coef_i[IDX_VW]);
      typ_q  <= nyc * $signed(coef_i[IDX_VH]);
      tzp_q  <= zc_q * dz.val;
      ez2_q  <= ez1_q;
      ovf2_q <= ovf1_q | dz.ovf;
    end
  end

  always_comb begin
    tx = sat32(wide_t'(txp_q >>> (F + 1)));
    ty = sat32(wide_t'(typ_q >>> (F + 1)));
    tz = sat32(wide_t'(tzp_q >>> F));
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      t_q[0] <= tx.val;
      t_q[1] <= ty.val;
      t_q[2] <= tz.val;
      ez3_q  <= ez2_q;
      ovf3_q <= ovf2_q | tx.ovf | ty.ovf | tz.ovf;
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[N-1];
  assign t_o     = t_q;
  assign ez_o    = ez3_q;
  assign ovf_o   = ovf3_q;
  assign busy_o  = |v_q;

endmodule

[rtl/vpts_div.sv]
// ----------------------------------------------------------------------------
// vpts_div
// Pipelined restoring divider for the perspective weight 2^(2F) / (-ez),
// four quotient bits per stage, with saturation at the end. A sideband
// word travels alongside.
// ----------------------------------------------------------------------------
module vpts_div import vpts_pkg::*; #(
  parameter int unsigned F  = 16,
  parameter int unsigned PW = 97
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  word_t         ez_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  input  logic          ready_i,
  output word_t         wc_o,
  output logic          wovf_o,
  output logic [PW-1:0] pay_o,
  output logic          busy_o
);

  localparam int unsigned NB  = 2 * F + 1;
  localparam int unsigned SPS = 4;
  localparam int unsigned NS  = (NB + SPS - 1) / SPS;
  localparam int unsigned QW  = NB;
  localparam int unsigned N   = NS + 2;

  logic [N-1:0] v_q;
  logic [N-1:0] en;

  logic [31:0]   mag_q  [NS+1];
  logic [31:0]   rem_q  [NS+1];
  logic [QW-1:0] quo_q  [NS+1];
  logic          neg_q  [NS+1];
  logic          zero_q [NS+1];
  logic [PW-1:0] pay_q  [N];

  logic [63:0] q64;
  word_t       wc_d;
  logic        wovf_d;
  word_t       wc_q;
  logic        wovf_q;

  always_comb begin
    en[N-1] = !v_q[N-1] || ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // The divisor is -ez; its magnitude is |ez| and its sign is the opposite.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mag_q[0]  <= ez_i[31] ? 32'(-(33'(ez_i))) : 32'(ez_i);
      neg_q[0]  <= (ez_i > 32'sd0);
      zero_q[0] <= (ez_i == 32'sd0);
      rem_q[0]  <= '0;
      quo_q[0]  <= '0;
      pay_q[0]  <= pay_i;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [31:0]   r;
    logic [32:0]   r2;
    logic [QW-1:0] q;
    logic          b;

    always_comb begin
      r = rem_q[k-1];
      q = quo_q[k-1];
      for (int j = 0; j < SPS; j++) begin
        if ((k - 1) * SPS + j < NB) begin
          // The dividend is a single one in its top bit, zeros below it.
          r2 = {r, ((k - 1) * SPS + j == 0)};
          b  = (r2 >= {1'b0, mag_q[k-1]});
          if (b) r2 = r2 - {1'b0, mag_q[k-1]};
          r = r2[31:0];
          q = {q[QW-2:0], b};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k]  <= r;
        quo_q[k]  <= q;
        mag_q[k]  <= mag_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
        pay_q[k]  <= pay_q[k-1];
      end
    end
  end

  always_comb begin
    q64    = 64'(quo_q[NS]);
    wovf_d = 1'b0;
    if (zero_q[NS]) begin
      wc_d   = 32'sh7fffffff;
      wovf_d = 1'b1;
    end else if (!neg_q[NS]) begin
      if (q64 > 64'd2147483647) begin
        wc_d   = 32'sh7fffffff;
        wovf_d = 1'b1;
      end else begin
        wc_d = q64[31:0];
      end
    end else begin
      if (q64 > 64'd2147483648) begin
        wc_d   = 32'sh80000000;
        wovf_d = 1'b1;
      end else begin
        wc_d = 32'(-q64);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[N-1]) begin
      wc_q       <= wc_d;
      wovf_q     <= wovf_d;
      pay_q[N-1] <= pay_q[NS];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[N-1];
  assign wc_o    = wc_q;
  assign wovf_o  = wovf_q;
  assign pay_o   = pay_q[N-1];
  assign busy_o  = |v_q;

endmodule

[rtl/vpts_view.sv]
// ----------------------------------------------------------------------------
// vpts_view
// Weighting by w and viewport offsets; the second stage is the output
// register of the block.
// ----------------------------------------------------------------------------
module vpts_view import vpts_pkg::*; #(
  parameter int unsigned F = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  coef_t coef_i,
  input  logic  ortho_i,
  input  logic  valid_i,
  output logic  ready_o,
  input  word_t t_i [3],
  input  word_t wc_i,
  input  logic  wovf_i,
  input  logic  ovf_i,
  output logic  valid_o,
  input  logic  ready_i,
  output word_t sx_o,
  output word_t sy_o,
  output word_t sz_o,
  output logic  ovf_o,
  output logic  busy_o
);

  localparam int unsigned N = 2;

  logic [N-1:0] v_q;
  logic [N-1:0] en;

  word_t              wsel;
  logic signed [63:0] pw_q [3];
  logic               ovf0_q;

  sat_t hx, hy, hz, sx, sy, sz;
  word_t sx_q, sy_q, sz_q;
  logic  ovf1_q;

  always_comb begin
    en[N-1] = !v_q[N-1] || ready_i;
    en[0]   = !v_q[0] || en[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
    end
  end

  assign wsel = ortho_i ? word_t'(32'd1 << F) : wc_i;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        pw_q[i] <= wsel * t_i[i];
      end
      ovf0_q <= ovf_i | (!ortho_i && wovf_i);
    end
  end

  always_comb begin
    hx = sat32(wide_t'(pw_q[0] >>> F));
    hy = sat32(wide_t'(pw_q[1] >>> F));
    hz = sat32(wide_t'(pw_q[2] >>> F));
    sx = sat32(wide_t'($signed(coef_i[IDX_VW]) >>> 1) + wide_t'($signed(coef_i[IDX_VL]))
               + wide_t'(hx.val));
    sy = sat32(wide_t'($signed(coef_i[IDX_VH]) >>> 1) + wide_t'($signed(coef_i[IDX_VT]))
               + wide_t'(hy.val));
    sz = sat32(wide_t'($signed(coef_i[IDX_VF])) + wide_t'(hz.val));
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sx_q   <= sx.val;
      sy_q   <= sy.val;
      sz_q   <= sz.val;
      ovf1_q <= ovf0_q | hx.ovf | hy.ovf | hz.ovf | sx.ovf | sy.ovf | sz.ovf;
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[N-1];
  assign sx_o    = sx_q;
  assign sy_o    = sy_q;
  assign sz_o    = sz_q;
  assign ovf_o   = ovf1_q;
  assign busy_o  = |v_q;

endmodule

[rtl/vertex_project_to_screen_core.sv]
// ----------------------------------------------------------------------------
// vertex_project_to_screen_core
// Fixed-point vertex pipeline: model-view transform, perspective or
// orthographic projection and viewport mapping, with saturation.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Contents
// s_axis    in         tuser: request kind (load or project)
//                      tdata: coef_index, coef_value, point_x, point_y, point_z
// m_axis    out        tuser: overflow
//                      tdata: screen_x, screen_y, screen_z
//
// A project request can enter every cycle while the pipeline is not held
// up by a stalled output; most of the pipeline depth lies in the divider,
// which retires four quotient bits a stage.
// A load request writes the coefficient table in the cycle it is accepted
// and gives no result. It is held off while any project request is still in
// the pipeline, as the eye, projection and viewport stages read the table directly.
// Reset clears the coefficient table and all valid bits. Each stage moves
// whenever its successor is empty or moving, so bubbles close up under a
// stalled output and nothing is lost or repeated.
module vertex_project_to_screen_core import vpts_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [4:0] coef_index, [36:5] coef_value, [68:37] point_x, [100:69] point_y,
  // [132:101] point_z, [135:133] zero.
  input  logic [135:0] s_axis_tdata,
  // [0] req_type.
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] screen_x, [63:32] screen_y, [95:64] screen_z.
  output logic [95:0]  m_axis_tdata,
  // [0] overflow.
  output logic         m_axis_tuser
);

  localparam int unsigned PW = 3 * 32 + 1;

  req_type_e        req_type;
  logic [IDX_W-1:0] coef_index;
  word_t            coef_value;
  word_t            point_x, point_y, point_z;

  coef_t coef_q;
  logic  ortho;
  logic  busy;
  logic  load_fire;

  logic  eye_ready, eye_valid, eye_busy, eye_ovf;
  word_t eye [3];
  logic  proj_ready, proj_valid, proj_busy, proj_ovf;
  word_t t [3];
  word_t ez;
  logic  div_ready, div_valid, div_busy, div_wovf;
  word_t div_wc;
  logic [PW-1:0] div_pay_in, div_pay_out;
  word_t t_d [3];
  logic  view_ready, view_busy, view_ovf;
  word_t sx, sy, sz;

  assign req_type   = req_type_e'(s_axis_tuser);
  assign coef_index = s_axis_tdata[4:0];
  assign coef_value = s_axis_tdata[36:5];
  assign point_x    = s_axis_tdata[68:37];
  assign point_y    = s_axis_tdata[100:69];
  assign point_z    = s_axis_tdata[132:101];

  assign busy  = eye_busy | proj_busy | div_busy | view_busy;
  assign ortho = (coef_q[IDX_MODE] != 32'd0);

  // Loads wait until every project request ahead of them has left.
  always_comb begin
    unique case (req_type)
      REQ_LOAD:    s_axis_tready = !busy;
      REQ_PROJECT: s_axis_tready = eye_ready;
      default:     s_axis_tready = 1'b0;
    endcase
  end

  assign load_fire = s_axis_tvalid && s_axis_tready && (req_type == REQ_LOAD);

  // Coefficient table; indices past the last entry are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (load_fire && (coef_index < IDX_W'(TABLE_DEPTH))) begin
      coef_q[coef_index] <= coef_value;
    end
  end

  vpts_eye #(.F(FRAC_BITS)) u_eye (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coef_i  (coef_q),
    .valid_i (s_axis_tvalid && (req_type == REQ_PROJECT)),
    .ready_o (eye_ready),
    .px_i    (point_x),
    .py_i    (point_y),
    .pz_i    (point_z),
    .valid_o (eye_valid),
    .ready_i (proj_ready),
    .eye_o   (eye),
    .ovf_o   (eye_ovf),
    .busy_o  (eye_busy)
  );

  vpts_proj #(.F(FRAC_BITS)) u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coef_i  (coef_q),
    .ortho_i (ortho),
    .valid_i (eye_valid),
    .ready_o (proj_ready),
    .eye_i   (eye),
    .ovf_i   (eye_ovf),
    .valid_o (proj_valid),
    .ready_i (div_ready),
    .t_o     (t),
    .ez_o    (ez),
    .ovf_o   (proj_ovf),
    .busy_o  (proj_busy)
  );

  // The scaled values and the overflow flag ride along with the divider.
  assign div_pay_in = {proj_ovf, t[2], t[1], t[0]};
  assign t_d[0]     = div_pay_out[31:0];
  assign t_d[1]     = div_pay_out[63:32];
  assign t_d[2]     = div_pay_out[95:64];

  vpts_div #(.F(FRAC_BITS), .PW(PW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (proj_valid),
    .ready_o (div_ready),
    .ez_i    (ez),
    .pay_i   (div_pay_in),
    .valid_o (div_valid),
    .ready_i (view_ready),
    .wc_o    (div_wc),
    .wovf_o  (div_wovf),
    .pay_o   (div_pay_out),
    .busy_o  (div_busy)
  );

  vpts_view #(.F(FRAC_BITS)) u_view (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coef_i  (coef_q),
    .ortho_i (ortho),
    .valid_i (div_valid),
    .ready_o (view_ready),
    .t_i     (t_d),
    .wc_i    (div_wc),
    .wovf_i  (div_wovf),
    .ovf_i   (div_pay_out[PW-1]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .sx_o    (sx),
    .sy_o    (sy),
    .sz_o    (sz),
    .ovf_o   (view_ovf),
    .busy_o  (view_busy)
  );

  assign m_axis_tdata = {sz, sy, sx};
  assign m_axis_tuser = view_ovf;

endmodule

[verif/vertex_project_to_screen_core_checker.sv]
// ----------------------------------------------------------------------------
// vertex_project_to_screen_core_checker
// Watches both channels of the vertex projection core, keeps its own copy of
// the coefficient table, predicts each screen point and compares it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vertex_project_to_screen_core_checker import vpts_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           errors_o,
  output int           pending_o
);

  localparam int FRAC = 16;

  typedef logic signed [79:0] big_t;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] sz;
    logic        ovf;
  } screen_pt_t;

  big_t       coefs[TABLE_DEPTH];
  screen_pt_t screen_q[$];

  // Floor of a*b / 2^s; the arithmetic shift rounds toward minus infinity.
  function automatic big_t fx_mul(big_t a, big_t b, int s);
    big_t p;
    p = a * b;
    return p >>> s;
  endfunction

  function automatic big_t clip32(big_t v, inout logic ovf);
    if (v > 80'sd2147483647) begin
      ovf = 1'b1;
      return 80'sd2147483647;
    end
    if (v < -80'sd2147483648) begin
      ovf = 1'b1;
      return -80'sd2147483648;
    end
    return v;
  endfunction

  function automatic screen_pt_t project_point(big_t x, big_t y, big_t z);
    big_t       eye[3];
    big_t       xc, yc, zc, wc, d, t, sx, sy, sz;
    logic       ovf;
    screen_pt_t r;
    ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      eye[i] = clip32(coefs[4*i+3] + fx_mul(coefs[4*i], x, FRAC)
                      + fx_mul(coefs[4*i+1], y, FRAC)
                      + fx_mul(coefs[4*i+2], z, FRAC), ovf);
    end
    if (coefs[IDX_MODE] == 0) begin
      // Perspective: w is the reciprocal of the negated eye depth.
      d  = -eye[2];
      xc = clip32(fx_mul(eye[0], coefs[IDX_P1], FRAC)
                  + fx_mul(eye[2], coefs[IDX_P2], FRAC), ovf);
      yc = clip32(fx_mul(eye[1], coefs[IDX_P3], FRAC)
                  + fx_mul(eye[2], coefs[IDX_P4], FRAC), ovf);
      zc = clip32(coefs[IDX_P6] + fx_mul(eye[2], coefs[IDX_P5], FRAC), ovf);
      if (d == 0) begin
        ovf = 1'b1;
        wc  = 80'sd2147483647;
      end else begin
        wc = clip32((big_t'(1) <<< (2*FRAC)) / d, ovf);
      end
    end else begin
      xc = clip32(coefs[IDX_P2] + fx_mul(eye[0], coefs[IDX_P1], FRAC), ovf);
      yc = clip32(coefs[IDX_P4] + fx_mul(eye[1], coefs[IDX_P3], FRAC), ovf);
      zc = clip32(coefs[IDX_P6] + fx_mul(eye[2], coefs[IDX_P5], FRAC), ovf);
      wc = big_t'(1) <<< FRAC;
    end
    t  = clip32(fx_mul(xc, coefs[IDX_VW], FRAC + 1), ovf);
    sx = clip32((coefs[IDX_VW] >>> 1) + coefs[IDX_VL]
                + clip32(fx_mul(wc, t, FRAC), ovf), ovf);
    t  = clip32(fx_mul(-yc, coefs[IDX_VH], FRAC + 1), ovf);
    sy = clip32((coefs[IDX_VH] >>> 1) + coefs[IDX_VT]
                + clip32(fx_mul(wc, t, FRAC), ovf), ovf);
    t  = clip32(coefs[IDX_VF] - coefs[IDX_VN], ovf);
    t  = clip32(fx_mul(zc, t, FRAC), ovf);
    sz = clip32(coefs[IDX_VF] + clip32(fx_mul(wc, t, FRAC), ovf), ovf);
    r.sx  = sx[31:0];
    r.sy  = sy[31:0];
    r.sz  = sz[31:0];
    r.ovf = ovf;
    return r;
  endfunction

  assign pending_o = screen_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    screen_pt_t want, got;
    if (!rst_ni) begin
      foreach (coefs[i]) coefs[i] = '0;
      screen_q.delete();
      errors_o = 0;
    end else begin
      // Requests update the table copy in acceptance order; the core holds
      // loads back until its pipeline drains, so this order is the true one.
      if (s_axis_tvalid && s_axis_tready) begin
        if (req_type_e'(s_axis_tuser) == REQ_LOAD) begin
          if (s_axis_tdata[4:0] < TABLE_DEPTH)
            coefs[s_axis_tdata[4:0]] = big_t'($signed(s_axis_tdata[36:5]));
        end else begin
          screen_q.push_back(project_point(big_t'($signed(s_axis_tdata[68:37])),
                                           big_t'($signed(s_axis_tdata[100:69])),
                                           big_t'($signed(s_axis_tdata[132:101]))));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
               m_axis_tuser};
        if (screen_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: unexpected result %h", $time, got);
        end else begin
          want = screen_q.pop_front();
          if (got.sx !== want.sx || got.sy !== want.sy || got.sz !== want.sz
              || got.ovf !== want.ovf) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: mismatch x %h/%h y %h/%h z %h/%h ovf %b/%b (exp/act)",
                       $time, want.sx, got.sx, want.sy, got.sy, want.sz, got.sz,
                       want.ovf, got.ovf);
          end
        end
      end
    end
  end

endmodule

[verif/vertex_project_to_screen_core_tb.sv]
// ----------------------------------------------------------------------------
// vertex_project_to_screen_core_tb
// Drives coefficient loads and point requests into the projection core with
// random gaps and output stalls; a checker predicts and compares every point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vertex_project_to_screen_core_tb;
  import vpts_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;
  int           errors;
  int           pending;

  // Stimulus controls for input gaps, output stalls and the watchdog.
  logic         no_gaps = 1'b0;
  logic         hold_req = 1'b0;
  logic         hold_done = 1'b0;
  int           hold_left = 0;
  int           quiet = 0;

  always #5 clk_i = ~clk_i;

  vertex_project_to_screen_core u_top (.*);

  vertex_project_to_screen_core_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .m_axis_tuser, .errors_o(errors), .pending_o(pending)
  );

  // Output side: random stalls, or one long stall when asked for.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done && hold_left == 0) begin
      hold_left = 300;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_gaps || ($urandom_range(99) >= 27);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet > 5000) begin
      $display("vertex_project_to_screen_core_tb: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [31:0] near_val(int unsigned mag);
    return $unsigned(int'($urandom_range(2 * mag)) - int'(mag));
  endfunction

  // Offer one request and wait until it is taken.
  task automatic offer(req_type_e kind, logic [4:0] idx, logic [31:0] val,
                       logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    while (!no_gaps && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, pz, py, px, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic load(int unsigned idx, logic [31:0] val);
    offer(REQ_LOAD, 5'(idx), val, $urandom, $urandom, $urandom);
  endtask

  task automatic project(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    offer(REQ_PROJECT, 5'($urandom), $urandom, px, py, pz);
  endtask

  // A sensible scene: moderate matrix, projection and viewport, then points.
  task automatic scene(int unsigned npts);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == IDX_MODE)
        load(i, ($urandom_range(1) == 0) ? 32'd0 : $urandom);
      else
        load(i, near_val(32'h0004_0000));
    end
    for (int i = 0; i < npts; i++) begin
      if ($urandom_range(9) == 0)
        project($urandom, $urandom, $urandom);
      else
        project(near_val(32'h0040_0000), near_val(32'h0040_0000),
                near_val(32'h0040_0000));
    end
  endtask

  initial begin
    int sent;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: an all-zero table is perspective with a zero divisor.
    project(32'h0, 32'h0, 32'h0);
    project(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    // Identity-like matrix with extremes, then orthographic mode.
    load(0, 32'h0001_0000);
    load(5, 32'h0001_0000);
    load(10, 32'h0001_0000);
    load(11, 32'hfffb_0000);
    load(IDX_P1, 32'h0001_0000);
    load(IDX_P3, 32'h0001_0000);
    load(IDX_VW, 32'h0280_0000);
    load(IDX_VH, 32'h01e0_0000);
    load(IDX_VF, 32'h7fffffff);
    load(IDX_VN, 32'h80000000);
    project(32'h0001_0000, 32'hffff_0000, 32'h0000_8000);
    project(32'h7fffffff, 32'h7fffffff, 32'h80000000);
    // Indexes beyond the table are dropped.
    load(25, 32'h1234_5678);
    load(31, 32'hffffffff);
    load(IDX_MODE, 32'h0000_0001);
    project(32'h0002_0000, 32'h0003_0000, 32'hfffe_0000);
    project(32'h80000000, 32'h80000000, 32'h80000000);
    load(IDX_MODE, 32'h80000000);
    project(32'h0, 32'h0, 32'h0);

    sent = 20;
    while (sent < 2000) begin
      int unsigned n;
      n = $urandom_range(15, 60);
      if (sent > 600 && sent < 700) begin
        // Let every outstanding point drain before the next scene.
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(posedge clk_i);
      end
      no_gaps  <= (sent > 1000 && sent < 1300);
      hold_req <= (sent > 300 && sent < 400);
      scene(n);
      sent += TABLE_DEPTH + n;
      // Random noise: any index, any value, any point.
      repeat ($urandom_range(1, 6)) begin
        offer(req_type_e'($urandom_range(1)), 5'($urandom), $urandom,
              $urandom, $urandom, $urandom);
        sent++;
      end
    end
    hold_req      <= 1'b0;
    no_gaps       <= 1'b0;
    s_axis_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("vertex_project_to_screen_core_tb: done, clean");
    end else begin
      $display("vertex_project_to_screen_core_tb: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/vpts_pkg.sv
rtl/vpts_eye.sv
rtl/vpts_proj.sv
rtl/vpts_div.sv
rtl/vpts_view.sv
rtl/vertex_project_to_screen_core.sv
verif/vertex_project_to_screen_core_checker.sv
verif/vertex_project_to_screen_core_tb.sv
